// ===== hw/rtl/spmq_pkg.sv =====
// ----------------------------------------------------------------------------
// spmq_pkg
// shared types, codes and defaults for the shared-pool multi-queue
// ----------------------------------------------------------------------------
package spmq_pkg;

   localparam int CELLS_DEF = 64;

   // operation codes
   localparam logic [2:0] FN_APPEND  = 3'd0;
   localparam logic [2:0] FN_INSERT  = 3'd1;
   localparam logic [2:0] FN_REM_HD  = 3'd2;
   localparam logic [2:0] FN_REM_TL  = 3'd3;
   localparam logic [2:0] FN_REM_POS = 3'd4;
   localparam logic [2:0] FN_COUNT   = 3'd5;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] data_in;
      logic [31:0] owner_id;
      logic [5:0]  position;
      logic [6:0]  count_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data_out;
      logic [6:0]  element_count;
   } rsp_type;

   typedef enum logic [4:0] {
      S_CLR,
      S_IDLE,
      S_FIND,
      S_NF,
      S_NEW0,
      S_NEW1,
      S_NEW2,
      S_RD_H,
      S_GOT_H,
      S_WALK_INS,
      S_WALK_TL,
      S_WALK_POS,
      S_WALK_CNT,
      S_RD_FREE,
      S_INS1,
      S_INS2,
      S_REM0,
      S_REM1,
      S_REM2,
      S_DROP0,
      S_DROP1,
      S_DONE
   } state_type;

endpackage

// ===== hw/rtl/spmq_ram.sv =====
// ----------------------------------------------------------------------------
// spmq_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module spmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/shared_pool_multi_queue.sv =====
// ----------------------------------------------------------------------------
// shared_pool_multi_queue
// per-owner queues kept as rings of linked cells in one shared pool
// ----------------------------------------------------------------------------
//  channel | direction | ports                        | item
//  req     | in        | req_valid, req_ready, req_data | operation (req_type)
//  rsp     | out       | rsp_valid, rsp_ready, rsp_data | result (rsp_type)
//
//  after reset a clearing pass rebuilds the free list, ready low
//  per item: a search of the owner table, then read-modify-write, with a walk
//  along the ring for insert/remove at position, remove tail and count
//  owner search and ring walk each use the single read port of their own memory
//  a finished item sits in the result register while the next one is taken
// ----------------------------------------------------------------------------
module shared_pool_multi_queue
   import spmq_pkg::*;
#(
   parameter int CELLS = CELLS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int OWNERS = CELLS / 2;
   localparam int LW     = (CELLS > 1) ? $clog2(CELLS) : 1;        // cell index
   localparam int OW     = (OWNERS > 1) ? $clog2(OWNERS) : 1;      // owner index
   localparam int OCW    = $clog2(OWNERS + 1);                     // owner count
   localparam int FW     = $clog2(CELLS + 1);                      // free count
   localparam int NW     = ($clog2(CELLS + 1) > 7) ? $clog2(CELLS + 1) : 7;
   localparam int OEW    = 32 + 2 * LW;                            // {id, tail, hold}

   // state and sequencer registers
   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [LW-1:0]    clr_ff, clr_in;
   logic [LW-1:0]    fh_ff, fh_in;          // free list head
   logic [FW-1:0]    free_ff, free_in;      // free cell count
   logic [OCW-1:0]   ocnt_ff, ocnt_in;      // active owners
   logic [OW-1:0]    scan_ff, scan_in;
   logic             chk_v_ff, chk_v_in;
   logic [OW-1:0]    chk_idx_ff, chk_idx_in;
   logic [OW-1:0]    k_ff, k_in;
   logic [LW-1:0]    tail_ff, tail_in;
   logic [LW-1:0]    hold_ff, hold_in;
   logic [LW-1:0]    cur_ff, cur_in;
   logic [NW-1:0]    c_ff, c_in;
   logic [LW-1:0]    needle_ff, needle_in;
   logic [LW-1:0]    sel_ff, sel_in;
   logic [LW-1:0]    nl_ff, nl_in;
   logic [LW-1:0]    nf_ff, nf_in;
   logic [LW-1:0]    e_ff, e_in;
   logic             upd_ff, upd_in;
   logic             single_ff, single_in;
   logic [1:0]       res_st_ff, res_st_in;
   logic [31:0]      res_dout_ff, res_dout_in;
   logic [6:0]       res_cnt_ff, res_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // memory ports
   logic             lk_we;
   logic [LW-1:0]    lk_waddr, lk_wdata, lk_raddr, lk_rdata;
   logic             dt_we;
   logic [LW-1:0]    dt_waddr, dt_raddr;
   logic [31:0]      dt_wdata, dt_rdata;
   logic             ow_we;
   logic [OW-1:0]    ow_waddr, ow_raddr;
   logic [OEW-1:0]   ow_wdata, ow_rdata;

   logic [31:0]      ow_rd_id;
   logic [LW-1:0]    ow_rd_tail, ow_rd_hold;
   logic [OCW-1:0]   ocnt_m1;
   logic [OW-1:0]    last_idx;
   logic [NW-1:0]    pos_w, lim_w;

   // link ring per cell, reset value built by the clearing pass
   spmq_ram #(.WIDTH(LW), .DEPTH(CELLS)) u_link (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (lk_waddr),
      .wr_data (lk_wdata),
      .rd_addr (lk_raddr),
      .rd_data (lk_rdata)
   );

   // stored data words
   spmq_ram #(.WIDTH(32), .DEPTH(CELLS)) u_data (
      .clock   (clock),
      .wr_en   (dt_we),
      .wr_addr (dt_waddr),
      .wr_data (dt_wdata),
      .rd_addr (dt_raddr),
      .rd_data (dt_rdata)
   );

   // owner table: id, tail cell and owner cell
   spmq_ram #(.WIDTH(OEW), .DEPTH(OWNERS)) u_owner (
      .clock   (clock),
      .wr_en   (ow_we),
      .wr_addr (ow_waddr),
      .wr_data (ow_wdata),
      .rd_addr (ow_raddr),
      .rd_data (ow_rdata)
   );

   assign ow_rd_id   = ow_rdata[OEW-1 -: 32];
   assign ow_rd_tail = ow_rdata[2*LW-1 -: LW];
   assign ow_rd_hold = ow_rdata[LW-1:0];
   assign ocnt_m1    = ocnt_ff - OCW'(1);
   assign last_idx   = ocnt_m1[OW-1:0];
   assign pos_w      = NW'(req_ff.position);
   assign lim_w      = NW'(req_ff.count_limit);

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      clr_in      = clr_ff;
      fh_in       = fh_ff;
      free_in     = free_ff;
      ocnt_in     = ocnt_ff;
      scan_in     = scan_ff;
      chk_v_in    = chk_v_ff;
      chk_idx_in  = chk_idx_ff;
      k_in        = k_ff;
      tail_in     = tail_ff;
      hold_in     = hold_ff;
      cur_in      = cur_ff;
      c_in        = c_ff;
      needle_in   = needle_ff;
      sel_in      = sel_ff;
      nl_in       = nl_ff;
      nf_in       = nf_ff;
      e_in        = e_ff;
      upd_in      = upd_ff;
      single_in   = single_ff;
      res_st_in   = res_st_ff;
      res_dout_in = res_dout_ff;
      res_cnt_in  = res_cnt_ff;
      rsp_in      = rsp_ff;

      lk_we    = 1'b0;
      lk_waddr = cur_ff;
      lk_wdata = cur_ff;
      lk_raddr = cur_ff;
      dt_we    = 1'b0;
      dt_waddr = fh_ff;
      dt_wdata = req_ff.data_in;
      dt_raddr = sel_ff;
      ow_we    = 1'b0;
      ow_waddr = k_ff;
      ow_wdata = {req_ff.owner_id, tail_ff, hold_ff};
      ow_raddr = scan_ff;

      // result register drains independently of the sequencer
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_CLR: begin
            // each cell links to the next, last back to cell 0
            lk_we    = 1'b1;
            lk_waddr = clr_ff;
            lk_wdata = (clr_ff == LW'(CELLS - 1)) ? '0 : clr_ff + LW'(1);
            clr_in   = clr_ff + LW'(1);
            if (clr_ff == LW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               res_st_in   = STAT_EMPTY;
               res_dout_in = '0;
               res_cnt_in  = '0;
               scan_in     = '0;
               chk_v_in    = 1'b0;
               state_in    = (ocnt_ff == '0) ? S_NF : S_FIND;
            end
         end

         S_FIND: begin
            // one owner entry read per cycle, compared in the cycle after
            ow_raddr = scan_ff;
            if (chk_v_ff && ow_rd_id == req_ff.owner_id) begin
               k_in     = chk_idx_ff;
               tail_in  = ow_rd_tail;
               hold_in  = ow_rd_hold;
               state_in = S_RD_H;
            end else if (chk_v_ff && chk_idx_ff == last_idx) begin
               state_in = S_NF;
            end else begin
               chk_v_in   = 1'b1;
               chk_idx_in = scan_ff;
               scan_in    = scan_ff + OW'(1);
            end
         end

         S_NF: begin
            // unknown owner
            if (req_ff.func == FN_APPEND || req_ff.func == FN_INSERT) begin
               if (free_ff >= FW'(2) && ocnt_ff < OCW'(OWNERS)) begin
                  state_in = S_NEW0;
               end else begin
                  res_st_in = STAT_FULL;
                  state_in  = S_DONE;
               end
            end else begin
               state_in = S_DONE;
            end
         end

         S_NEW0: begin
            lk_raddr = fh_ff;
            state_in = S_NEW1;
         end

         S_NEW1: begin
            // data cell is the second free cell
            e_in     = lk_rdata;
            lk_raddr = lk_rdata;
            state_in = S_NEW2;
         end

         S_NEW2: begin
            lk_we     = 1'b1;
            lk_waddr  = e_ff;
            lk_wdata  = e_ff;
            dt_we     = 1'b1;
            dt_waddr  = e_ff;
            ow_we     = 1'b1;
            ow_waddr  = ocnt_ff[OW-1:0];
            ow_wdata  = {req_ff.owner_id, e_ff, fh_ff};
            fh_in     = lk_rdata;
            free_in   = free_ff - FW'(2);
            ocnt_in   = ocnt_ff + OCW'(1);
            res_st_in = STAT_OK;
            state_in  = S_DONE;
         end

         S_RD_H: begin
            lk_raddr = tail_ff;
            state_in = S_GOT_H;
         end

         S_GOT_H: begin
            // lk_rdata holds the head cell
            cur_in    = lk_rdata;
            c_in      = NW'(1);
            lk_raddr  = lk_rdata;
            single_in = (lk_rdata == tail_ff);
            needle_in = tail_ff;
            sel_in    = lk_rdata;
            unique case (req_ff.func)
               FN_APPEND, FN_INSERT: begin
                  if (free_ff == '0) begin
                     res_st_in = STAT_FULL;
                     state_in  = S_DONE;
                  end else if (req_ff.func == FN_APPEND || req_ff.position == '0) begin
                     // link in right after the tail
                     nl_in    = lk_rdata;
                     upd_in   = (req_ff.func == FN_APPEND);
                     state_in = S_RD_FREE;
                  end else begin
                     state_in = S_WALK_INS;
                  end
               end
               FN_REM_HD: begin
                  state_in = S_REM0;
               end
               FN_REM_TL: begin
                  state_in = (lk_rdata == tail_ff) ? S_REM0 : S_WALK_TL;
               end
               FN_REM_POS: begin
                  if (req_ff.position == '0) begin
                     state_in = S_REM0;
                  end else if (lk_rdata == tail_ff) begin
                     state_in = S_DONE;
                  end else begin
                     single_in = 1'b0;
                     state_in  = S_WALK_POS;
                  end
               end
               FN_COUNT: begin
                  state_in = S_WALK_CNT;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_WALK_INS: begin
            // lk_rdata is the link of cur
            if (c_ff == pos_w || cur_ff == tail_ff) begin
               needle_in = cur_ff;
               nl_in     = lk_rdata;
               upd_in    = (cur_ff == tail_ff);
               state_in  = S_RD_FREE;
            end else begin
               cur_in   = lk_rdata;
               c_in     = c_ff + NW'(1);
               lk_raddr = lk_rdata;
            end
         end

         S_WALK_TL: begin
            // find the cell before the tail
            if (lk_rdata == tail_ff) begin
               needle_in = cur_ff;
               sel_in    = tail_ff;
               single_in = 1'b0;
               state_in  = S_REM0;
            end else begin
               cur_in   = lk_rdata;
               lk_raddr = lk_rdata;
            end
         end

         S_WALK_POS: begin
            if (c_ff == pos_w) begin
               needle_in = cur_ff;
               sel_in    = lk_rdata;
               state_in  = S_REM0;
            end else if (lk_rdata == tail_ff) begin
               state_in = S_DONE;            // position past the end
            end else begin
               cur_in   = lk_rdata;
               c_in     = c_ff + NW'(1);
               lk_raddr = lk_rdata;
            end
         end

         S_WALK_CNT: begin
            if (cur_ff == tail_ff || c_ff >= NW'(CELLS)) begin
               res_st_in  = STAT_OK;
               res_cnt_in = (lim_w != '0 && c_ff > lim_w) ? req_ff.count_limit : c_ff[6:0];
               state_in   = S_DONE;
            end else begin
               cur_in   = lk_rdata;
               c_in     = c_ff + NW'(1);
               lk_raddr = lk_rdata;
            end
         end

         S_RD_FREE: begin
            lk_raddr = fh_ff;
            state_in = S_INS1;
         end

         S_INS1: begin
            // new cell is the free head
            nf_in    = lk_rdata;
            lk_we    = 1'b1;
            lk_waddr = fh_ff;
            lk_wdata = nl_ff;
            dt_we    = 1'b1;
            dt_waddr = fh_ff;
            state_in = S_INS2;
         end

         S_INS2: begin
            lk_we     = 1'b1;
            lk_waddr  = needle_ff;
            lk_wdata  = fh_ff;
            ow_we     = upd_ff;
            ow_wdata  = {req_ff.owner_id, fh_ff, hold_ff};
            fh_in     = nf_ff;
            free_in   = free_ff - FW'(1);
            res_st_in = STAT_OK;
            state_in  = S_DONE;
         end

         S_REM0: begin
            lk_raddr = sel_ff;
            dt_raddr = sel_ff;
            state_in = S_REM1;
         end

         S_REM1: begin
            // unlink sel from behind needle
            res_dout_in = dt_rdata;
            res_st_in   = STAT_OK;
            lk_we       = 1'b1;
            lk_waddr    = needle_ff;
            lk_wdata    = lk_rdata;
            ow_we       = (sel_ff == tail_ff) && !single_ff;
            ow_wdata    = {req_ff.owner_id, needle_ff, hold_ff};
            state_in    = S_REM2;
         end

         S_REM2: begin
            // return sel to the pool
            lk_we    = 1'b1;
            lk_waddr = sel_ff;
            lk_wdata = fh_ff;
            fh_in    = sel_ff;
            free_in  = free_ff + FW'(1);
            state_in = single_ff ? S_DROP0 : S_DONE;
         end

         S_DROP0: begin
            // last element gone: free the owner cell, fetch last entry
            lk_we    = 1'b1;
            lk_waddr = hold_ff;
            lk_wdata = fh_ff;
            fh_in    = hold_ff;
            free_in  = free_ff + FW'(1);
            ow_raddr = last_idx;
            state_in = S_DROP1;
         end

         S_DROP1: begin
            ow_we    = 1'b1;
            ow_waddr = k_ff;
            ow_wdata = ow_rdata;
            ocnt_in  = ocnt_m1;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = res_st_ff;
               rsp_in.data_out      = res_dout_ff;
               rsp_in.element_count = res_cnt_ff;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         fh_ff        <= '0;
         free_ff      <= FW'(CELLS);
         ocnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         chk_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fh_ff        <= fh_in;
         free_ff      <= free_in;
         ocnt_ff      <= ocnt_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_v_ff     <= chk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_ff     <= scan_in;
      chk_idx_ff  <= chk_idx_in;
      k_ff        <= k_in;
      tail_ff     <= tail_in;
      hold_ff     <= hold_in;
      cur_ff      <= cur_in;
      c_ff        <= c_in;
      needle_ff   <= needle_in;
      sel_ff      <= sel_in;
      nl_ff       <= nl_in;
      nf_ff       <= nf_in;
      e_ff        <= e_in;
      upd_ff      <= upd_in;
      single_ff   <= single_in;
      res_st_ff   <= res_st_in;
      res_dout_ff <= res_dout_in;
      res_cnt_ff  <= res_cnt_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ===== tb/shared_pool_multi_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shared_pool_multi_queue_tb
// self-checking bench: directed table then random traffic on a small owner
// set, every result compared with a behavioral model of the queue pool
// ----------------------------------------------------------------------------
module shared_pool_multi_queue_tb;
   import spmq_pkg::*;

   localparam int NCELL      = CELLS_DEF;
   localparam int NOWN       = NCELL / 2;
   localparam int N_RANDOM   = 1625;
   localparam int WATCH_LIM  = 20000;
   localparam int DRAIN_WAIT = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   shared_pool_multi_queue #(.CELLS(NCELL)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // pool model: linked cells, owners as rings with a tail pointer
   // ---------------------------------------------------------------------
   logic [31:0] pool_word [NCELL];
   int          pool_next [NCELL];
   logic [31:0] own_id    [NOWN];
   int          own_tail  [NOWN];
   int          own_cell  [NOWN];
   int          n_owners, free_top, n_free;

   rsp_type     pending_rsp [$];
   int          n_errors = 0;
   int          n_results = 0;
   int          idle_cycles = 0;
   int          n_full = 0, n_empty = 0;

   function automatic void pool_clear();
      for (int i = 0; i < NCELL; i++) begin
         pool_next[i] = (i + 1) % NCELL;
         pool_word[i] = '0;
      end
      n_owners = 0;
      free_top = 0;
      n_free   = NCELL;
   endfunction

   function automatic int grab_cell();
      int c;
      c = free_top;
      free_top = pool_next[c];
      n_free--;
      return c;
   endfunction

   function automatic void release_cell(int c);
      pool_next[c] = free_top;
      free_top = c;
      n_free++;
   endfunction

   function automatic int owner_slot(logic [31:0] id);
      for (int i = 0; i < n_owners; i++)
         if (own_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void retire_owner(int k);
      int last;
      last = n_owners - 1;
      release_cell(own_cell[k]);
      own_id[k]   = own_id[last];
      own_tail[k] = own_tail[last];
      own_cell[k] = own_cell[last];
      n_owners    = last;
   endfunction

   function automatic logic [31:0] pop_front(int k);
      int t, h;
      logic [31:0] w;
      t = own_tail[k];
      h = pool_next[t];
      w = pool_word[h];
      if (h == t) begin
         release_cell(h);
         retire_owner(k);
      end else begin
         pool_next[t] = pool_next[h];
         release_cell(h);
      end
      return w;
   endfunction

   function automatic int ring_len(int k);
      int t, c, n;
      t = own_tail[k];
      c = pool_next[t];
      n = 1;
      while (c != t && n < NCELL) begin
         c = pool_next[c];
         n++;
      end
      return n;
   endfunction

   // adds a word for the owner, at the tail or at a position
   function automatic void store_word(int k, logic [31:0] id, logic [31:0] w,
                                      int pos, bit at_pos);
      int e, t, h, nd, i, oc;
      if (k < 0) begin
         oc = grab_cell();
         e  = grab_cell();
         pool_word[e] = w;
         pool_next[e] = e;
         own_id[n_owners]   = id;
         own_tail[n_owners] = e;
         own_cell[n_owners] = oc;
         n_owners++;
         return;
      end
      t = own_tail[k];
      h = pool_next[t];
      e = grab_cell();
      pool_word[e] = w;
      if (at_pos && pos == 0) begin
         pool_next[e] = h;
         pool_next[t] = e;
         return;
      end
      nd = t;
      if (at_pos) begin
         nd = h;
         i = 1;
         while (i != pos && nd != t && i < NCELL) begin
            nd = pool_next[nd];
            i++;
         end
      end
      pool_next[e] = pool_next[nd];
      pool_next[nd] = e;
      if (nd == t) own_tail[k] = e;
   endfunction

   function automatic rsp_type pool_apply(req_type rq);
      rsp_type r;
      int k, t, h, p, g, nd, i, sel, pos, cnt;
      r = '{status: STAT_EMPTY, data_out: '0, element_count: '0};
      pos = rq.position;
      k = owner_slot(rq.owner_id);
      case (rq.func)
         FN_APPEND, FN_INSERT: begin
            if (k >= 0) r.status = (n_free >= 1) ? STAT_OK : STAT_FULL;
            else r.status = (n_free >= 2 && n_owners < NOWN) ? STAT_OK : STAT_FULL;
            if (r.status == STAT_OK)
               store_word(k, rq.owner_id, rq.data_in, pos, rq.func == FN_INSERT);
         end
         FN_REM_HD: if (k >= 0) begin
            r.data_out = pop_front(k);
            r.status = STAT_OK;
         end
         FN_REM_TL: if (k >= 0) begin
            t = own_tail[k];
            h = pool_next[t];
            r.status = STAT_OK;
            if (h == t) r.data_out = pop_front(k);
            else begin
               p = h;
               g = 0;
               while (pool_next[p] != t && g < NCELL) begin
                  p = pool_next[p];
                  g++;
               end
               r.data_out = pool_word[t];
               pool_next[p] = pool_next[t];
               own_tail[k] = p;
               release_cell(t);
            end
         end
         FN_REM_POS: if (k >= 0) begin
            t = own_tail[k];
            h = pool_next[t];
            if (pos == 0) begin
               r.data_out = pop_front(k);
               r.status = STAT_OK;
            end else if (h != t) begin
               nd = h;
               i = 0;
               while (i < pos - 1 && pool_next[nd] != t) begin
                  nd = pool_next[nd];
                  i++;
               end
               if (i >= pos - 1) begin
                  sel = pool_next[nd];
                  r.data_out = pool_word[sel];
                  pool_next[nd] = pool_next[sel];
                  if (sel == t) own_tail[k] = nd;
                  release_cell(sel);
                  r.status = STAT_OK;
               end
            end
         end
         FN_COUNT: if (k >= 0) begin
            cnt = ring_len(k);
            if (rq.count_limit != 0 && cnt > rq.count_limit) cnt = rq.count_limit;
            r.element_count = cnt[6:0];
            r.status = STAT_OK;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      n_errors++;
   endtask

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   // most often no gap, otherwise mostly a short one, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   // drops valid for a number of cycles, nothing when the gap is zero
   task automatic idle_gap(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // sends one item; holds valid until accepted, then predicts
   task automatic send_item(req_type rq);
      rsp_type r;
      req_data  <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = pool_apply(rq);
      pending_rsp.push_back(r);
      @(negedge clock);
   endtask

   // small owner set so queues get long and owners get reused; a few wild ids
   logic [31:0] id_pool [6] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                                32'h5A5A_A5A5, 32'h0000_0002};

   function automatic req_type rand_item(int phase);
      req_type rq;
      int r;
      r = $urandom_range(0, 99);
      // fill phases lean toward adds, drain phases toward removes
      if (phase == 0) rq.func = (r < 70) ? ((r < 40) ? FN_APPEND : FN_INSERT)
                                          : 3'($urandom_range(2, 5));
      else rq.func = (r < 25) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(2, 5));
      if ($urandom_range(0, 49) == 0) rq.func = 3'($urandom_range(6, 7));
      rq.data_in  = $urandom();
      rq.owner_id = ($urandom_range(0, 19) == 0) ? $urandom()
                                                 : id_pool[$urandom_range(0, 5)];
      if ($urandom_range(0, 2) == 0)
         rq.owner_id = 32'h100 + $urandom_range(0, 35);
      rq.position    = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 6));
      rq.count_limit = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 5));
      return rq;
   endfunction

   // ---------------------------------------------------------------------
   // directed table: expected result given where it is obvious
   // ---------------------------------------------------------------------
   typedef struct {
      req_type rq;
      bit      known;
      rsp_type want;
   } row_type;

   localparam int N_ROWS = 25;
   row_type rows [N_ROWS];

   function automatic req_type mk(logic [2:0] f, logic [31:0] d, logic [31:0] id,
                                  logic [5:0] p, logic [6:0] l);
      req_type rq;
      rq = '{func: f, data_in: d, owner_id: id, position: p, count_limit: l};
      return rq;
   endfunction

   function automatic row_type row(req_type rq, bit known, logic [1:0] st,
                                   logic [31:0] d, logic [6:0] c);
      row_type w;
      w.rq = rq;
      w.known = known;
      w.want = '{status: st, data_out: d, element_count: c};
      return w;
   endfunction

   initial begin
      // unknown owner after reset: every remove and count is empty
      rows[0]  = row(mk(FN_REM_HD,  0, 32'h7, 0, 0), 1, STAT_EMPTY, 0, 0);
      rows[1]  = row(mk(FN_REM_TL,  0, 32'h7, 0, 0), 1, STAT_EMPTY, 0, 0);
      rows[2]  = row(mk(FN_REM_POS, 0, 32'h7, 63, 0), 1, STAT_EMPTY, 0, 0);
      rows[3]  = row(mk(FN_COUNT,   0, 32'h7, 0, 64), 1, STAT_EMPTY, 0, 0);
      rows[4]  = row(mk(3'd6, 32'hFFFF_FFFF, 0, 63, 127), 1, STAT_EMPTY, 0, 0);
      // new owner, insert is a plain append; extremes of data and id
      rows[5]  = row(mk(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 63, 0), 1, STAT_OK, 0, 0);
      rows[6]  = row(mk(FN_APPEND, 32'h0, 32'hFFFF_FFFF, 0, 0), 1, STAT_OK, 0, 0);
      rows[7]  = row(mk(FN_INSERT, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 0, 0), 0, '0, 0, 0);
      rows[8]  = row(mk(FN_INSERT, 32'h1234_5678, 32'hFFFF_FFFF, 63, 0), 0, '0, 0, 0);
      rows[9]  = row(mk(FN_INSERT, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 2, 0), 0, '0, 0, 0);
      rows[10] = row(mk(FN_COUNT, 0, 32'hFFFF_FFFF, 0, 0), 1, STAT_OK, 0, 5);
      rows[11] = row(mk(FN_COUNT, 0, 32'hFFFF_FFFF, 0, 3), 1, STAT_OK, 0, 3);
      rows[12] = row(mk(FN_REM_POS, 0, 32'hFFFF_FFFF, 63, 0), 1, STAT_EMPTY, 0, 0);
      rows[13] = row(mk(FN_REM_POS, 0, 32'hFFFF_FFFF, 2, 0), 0, '0, 0, 0);
      rows[14] = row(mk(FN_REM_TL, 0, 32'hFFFF_FFFF, 0, 0), 0, '0, 0, 0);
      rows[15] = row(mk(FN_REM_HD, 0, 32'hFFFF_FFFF, 0, 0), 0, '0, 0, 0);
      rows[16] = row(mk(FN_REM_POS, 0, 32'hFFFF_FFFF, 0, 0), 0, '0, 0, 0);
      // last element gone: owner deleted
      rows[17] = row(mk(FN_REM_TL, 0, 32'hFFFF_FFFF, 0, 0), 0, '0, 0, 0);
      rows[18] = row(mk(FN_COUNT, 0, 32'hFFFF_FFFF, 0, 0), 1, STAT_EMPTY, 0, 0);
      rows[19] = row(mk(FN_APPEND, 32'h1, 32'h0, 0, 0), 1, STAT_OK, 0, 0);
      rows[20] = row(mk(FN_REM_POS, 0, 32'h0, 1, 0), 1, STAT_EMPTY, 0, 0);
      rows[21] = row(mk(FN_REM_HD, 0, 32'h0, 0, 0), 1, STAT_OK, 32'h1, 0);
      rows[22] = row(mk(3'd7, 0, 32'h0, 0, 0), 1, STAT_EMPTY, 0, 0);
      rows[23] = row(mk(FN_APPEND, 32'hDEAD_BEEF, 32'h0, 0, 0), 1, STAT_OK, 0, 0);
      rows[24] = row(mk(FN_REM_POS, 0, 32'h0, 0, 0), 1, STAT_OK, 32'hDEAD_BEEF, 0);
   end

   // ---------------------------------------------------------------------
   // result side: random stall, compare with oldest prediction
   // ---------------------------------------------------------------------
   rsp_type typed_want [$];
   bit      typed_known [$];

   initial begin
      int hold;
      rsp_type want;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = gap_len();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         n_results++;
         if (pending_rsp.size() == 0) begin
            $display("unexpected result at %0t", $realtime);
            n_errors++;
         end else begin
            want = pending_rsp.pop_front();
            // a typed-in row must also agree with the model
            if (typed_known.size() != 0) begin
               if (typed_known.pop_front() && typed_want[0] != want)
                  report_mismatch("table vs model", 32'(typed_want[0].status),
                                  32'(want.status));
               void'(typed_want.pop_front());
            end
            if (rsp_data.status != want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.data_out != want.data_out)
               report_mismatch("data_out", rsp_data.data_out, want.data_out);
            if (rsp_data.element_count != want.element_count)
               report_mismatch("element_count", 32'(rsp_data.element_count),
                               32'(want.element_count));
            if (want.status == STAT_FULL) n_full++;
            if (want.status == STAT_EMPTY) n_empty++;
         end
         @(negedge clock);
      end
   end

   // watchdog: cycles with no accepted item on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIM) begin
         $display("watchdog expired, %0d results outstanding", pending_rsp.size());
         $display("shared_pool_multi_queue regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int phase;
      int gap;
      pool_clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         typed_known.push_back(rows[i].known);
         typed_want.push_back(rows[i].want);
         idle_gap(gap_len());
         send_item(rows[i].rq);
      end

      // alternate fill and drain so the pool hits full and owners come and go
      for (int i = 0; i < N_RANDOM; i++) begin
         phase = (i / 150) % 2;
         if ((i % 300) >= 200 && (i % 300) < 260) phase = 0;
         gap = 0;
         if ($urandom_range(0, 3) != 0 || i % 400 < 40) begin
            gap = gap_len();
         end
         idle_gap(gap);
         send_item(rand_item(phase));
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("%0d items sent, %0d results checked (%0d full, %0d empty status)",
               N_ROWS + N_RANDOM, n_results, n_full, n_empty);
      if (n_errors == 0)
         $display("shared_pool_multi_queue regression: pass");
      else
         $display("shared_pool_multi_queue regression: fail");
      $finish;
   end

endmodule
